// ===== hw/rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Item payloads, coefficient bundle, inter-stage records and register codes.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int DIV_STEPS = 64;

	localparam logic [2:0] REG_T1    = 3'd0;
	localparam logic [2:0] REG_T2_T3 = 3'd1;
	localparam logic [2:0] REG_P1    = 3'd2;
	localparam logic [2:0] REG_P2_P3 = 3'd3;
	localparam logic [2:0] REG_P4_P5 = 3'd4;
	localparam logic [2:0] REG_P6_P7 = 3'd5;
	localparam logic [2:0] REG_P8_P9 = 3'd6;

	localparam logic signed [32:0] TEMP_OFFSET = 33'sd128000;
	localparam logic [63:0]        P_BIAS      = 64'h0000_8000_0000_0000;
	localparam logic [11:0]        P_SCALE     = 12'd3125;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic signed [31:0] pressure_q24_8;
		logic               status;
	} result_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} coeff_t;

	// temperature side hands over compensated temperature and centred fine value
	typedef struct packed {
		logic [31:0] temp;
		logic [32:0] a;
		logic [19:0] raw_pressure;
	} fine_t;

	typedef struct packed {
		logic [63:0] num;
		logic [63:0] den;
		logic [31:0] temp;
	} quot_req_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] quo;
		logic [63:0] den;
		logic        qneg;
		logic        zero;
		logic [31:0] temp;
	} div_stage_t;

endpackage

// ===== hw/rtl/pressure_temperature_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: barometric sample compensation pipeline
// Takes one item per cycle unless a stalled result freezes the whole pipe;
// the divider's 64 quotient-bit stages make up most of the depth.
// Reset clears all valid bits and the coefficient registers to zero.
// A stalled result freezes every stage, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  ptc_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output ptc_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	logic [15:0] t1_q, p1_q;
	logic [31:0] t23_q, p23_q, p45_q, p67_q, p89_q;
	ptc_pkg::coeff_t coef;

	logic                 en;
	logic                 fine_vld, req_vld, div_vld;
	ptc_pkg::fine_t       fine;
	ptc_pkg::quot_req_t   req;
	ptc_pkg::div_stage_t  div_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t23_q <= '0;
			p1_q  <= '0;
			p23_q <= '0;
			p45_q <= '0;
			p67_q <= '0;
			p89_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptc_pkg::REG_T1:    t1_q  <= cfg_data[15:0];
				ptc_pkg::REG_T2_T3: t23_q <= cfg_data;
				ptc_pkg::REG_P1:    p1_q  <= cfg_data[15:0];
				ptc_pkg::REG_P2_P3: p23_q <= cfg_data;
				ptc_pkg::REG_P4_P5: p45_q <= cfg_data;
				ptc_pkg::REG_P6_P7: p67_q <= cfg_data;
				ptc_pkg::REG_P8_P9: p89_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.t1 = t1_q;
		coef.t2 = t23_q[15:0];
		coef.t3 = t23_q[31:16];
		coef.p1 = p1_q;
		coef.p2 = p23_q[15:0];
		coef.p3 = p23_q[31:16];
		coef.p4 = p45_q[15:0];
		coef.p5 = p45_q[31:16];
		coef.p6 = p67_q[15:0];
		coef.p7 = p67_q[31:16];
		coef.p8 = p89_q[15:0];
		coef.p9 = p89_q[31:16];
	end

	// advance the whole pipe unless the output holds a result being stalled
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	ptc_temp u_temp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (sample_valid),
		.in     (sample),
		.coef   (coef),
		.out_vld(fine_vld),
		.out    (fine)
	);

	ptc_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (fine_vld),
		.in     (fine),
		.coef   (coef),
		.out_vld(req_vld),
		.out    (req)
	);

	ptc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (req_vld),
		.in     (req),
		.out_vld(div_vld),
		.out    (div_out)
	);

	ptc_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (div_vld),
		.in     (div_out),
		.coef   (coef),
		.out_vld(result_valid),
		.out    (result)
	);

	a_zero_div_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status |->
			result.pressure_q24_8 == '0 && result.temperature_centi == '0)
		else $error("zero divisor result carries nonzero values");

	a_new_result_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_stall))
		else $error("result appeared while pipeline was frozen");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("input stalled with empty output register");

endmodule

// ===== hw/rtl/ptc_temp.sv =====
// ----------------------------------------------------------------------------
// ptc_temp: temperature compensation stages
// Four stages of 32-bit wrapping arithmetic giving temperature and fine value.
// ----------------------------------------------------------------------------
module ptc_temp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  ptc_pkg::sample_t in,
	input  ptc_pkg::coeff_t  coef,
	output logic             out_vld,
	output ptc_pkg::fine_t   out
);

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [33:0] xt2_s1, dd_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3;
	logic [31:0]        v1_s2;
	logic signed [35:0] ddt3_s2;
	logic [31:0]        fine_s3;
	ptc_pkg::fine_t     fine_s4;

	logic signed [17:0] x;
	logic signed [16:0] d;
	logic [31:0]        f5;

	always_comb begin
		x  = $signed({1'b0, in.raw_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
		d  = $signed({1'b0, in.raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
		f5 = fine_s3 * 32'd5 + 32'd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xt2_s1  <= x * $signed(coef.t2);
			dd_s1   <= d * d;
			rp_s1   <= in.raw_pressure;

			v1_s2   <= 32'($signed(xt2_s1[31:0]) >>> 11);
			ddt3_s2 <= $signed(dd_s1[31:12]) * $signed(coef.t3);
			rp_s2   <= rp_s1;

			fine_s3 <= v1_s2 + 32'($signed(ddt3_s2[31:0]) >>> 14);
			rp_s3   <= rp_s2;

			fine_s4.temp         <= 32'($signed(f5) >>> 8);
			fine_s4.a            <= $signed({fine_s3[31], fine_s3}) - ptc_pkg::TEMP_OFFSET;
			fine_s4.raw_pressure <= rp_s3;
		end
	end

	assign out_vld = vld_s4;
	assign out     = fine_s4;

endmodule

// ===== hw/rtl/ptc_prep.sv =====
// ----------------------------------------------------------------------------
// ptc_prep: pressure dividend and divisor stages
// Eight stages of 64-bit wrapping products and sums, products split at 32 bits.
// ----------------------------------------------------------------------------
module ptc_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  ptc_pkg::fine_t      in,
	input  ptc_pkg::coeff_t     coef,
	output logic                out_vld,
	output ptc_pkg::quot_req_t  out
);

	logic [7:0] vld_s;

	// stage 5
	logic [63:0] aa_s5;
	logic signed [48:0] ap5_s5, ap2_s5;
	logic [20:0] p_s5;
	logic [31:0] t_s5;
	// stage 6
	logic signed [48:0] pp6lo_s6, pp3lo_s6, ap5_s6, ap2_s6;
	logic [31:0] pp6hi_s6, pp3hi_s6;
	logic [20:0] p_s6;
	logic [31:0] t_s6;
	// stage 7
	logic [63:0] b6_s7, aap3_s7;
	logic signed [48:0] ap5_s7, ap2_s7;
	logic [20:0] p_s7;
	logic [31:0] t_s7;
	// stage 8
	logic [63:0] b_s8, a2_s8;
	logic [20:0] p_s8;
	logic [31:0] t_s8;
	// stage 9
	logic [63:0] b_s9, a3_s9;
	logic [20:0] p_s9;
	logic [31:0] t_s9;
	// stage 10
	logic [63:0] nb_s10;
	logic [47:0] a3lo_s10;
	logic [31:0] a3hi_s10;
	logic [31:0] t_s10;
	// stage 11
	logic [63:0] a4_s11;
	logic [43:0] nlo_s11;
	logic [31:0] nhi_s11;
	logic [31:0] t_s11;
	// stage 12
	ptc_pkg::quot_req_t req_s12;

	logic signed [65:0] aa_full;

	always_comb begin
		aa_full = $signed(in.a) * $signed(in.a);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s5    <= aa_full[63:0];
			ap5_s5   <= $signed(in.a) * $signed(coef.p5);
			ap2_s5   <= $signed(in.a) * $signed(coef.p2);
			p_s5     <= 21'h100000 - {1'b0, in.raw_pressure};
			t_s5     <= in.temp;

			pp6lo_s6 <= $signed({1'b0, aa_s5[31:0]}) * $signed(coef.p6);
			pp3lo_s6 <= $signed({1'b0, aa_s5[31:0]}) * $signed(coef.p3);
			pp6hi_s6 <= aa_s5[63:32] * {{16{coef.p6[15]}}, coef.p6};
			pp3hi_s6 <= aa_s5[63:32] * {{16{coef.p3[15]}}, coef.p3};
			ap5_s6   <= ap5_s5;
			ap2_s6   <= ap2_s5;
			p_s6     <= p_s5;
			t_s6     <= t_s5;

			b6_s7    <= {{15{pp6lo_s6[48]}}, pp6lo_s6} + {pp6hi_s6, 32'b0};
			aap3_s7  <= {{15{pp3lo_s6[48]}}, pp3lo_s6} + {pp3hi_s6, 32'b0};
			ap5_s7   <= ap5_s6;
			ap2_s7   <= ap2_s6;
			p_s7     <= p_s6;
			t_s7     <= t_s6;

			b_s8     <= b6_s7 + {ap5_s7[46:0], 17'b0};
			a2_s8    <= 64'($signed(aap3_s7) >>> 8) + {{3{ap2_s7[48]}}, ap2_s7, 12'b0};
			p_s8     <= p_s7;
			t_s8     <= t_s7;

			b_s9     <= b_s8 + {{13{coef.p4[15]}}, coef.p4, 35'b0};
			a3_s9    <= ptc_pkg::P_BIAS + a2_s8;
			p_s9     <= p_s8;
			t_s9     <= t_s8;

			nb_s10   <= {12'b0, p_s9, 31'b0} - b_s9;
			a3lo_s10 <= a3_s9[31:0] * coef.p1;
			a3hi_s10 <= a3_s9[63:32] * {16'b0, coef.p1};
			t_s10    <= t_s9;

			a4_s11   <= {16'b0, a3lo_s10} + {a3hi_s10, 32'b0};
			nlo_s11  <= nb_s10[31:0] * ptc_pkg::P_SCALE;
			nhi_s11  <= nb_s10[63:32] * {20'b0, ptc_pkg::P_SCALE};
			t_s11    <= t_s10;

			req_s12.den  <= 64'($signed(a4_s11) >>> 33);
			req_s12.num  <= {20'b0, nlo_s11} + {nhi_s11, 32'b0};
			req_s12.temp <= t_s11;
		end
	end

	assign out_vld = vld_s[7];
	assign out     = req_s12;

endmodule

// ===== hw/rtl/ptc_div.sv =====
// ----------------------------------------------------------------------------
// ptc_div: pipelined signed 64-bit divider
// Magnitude stage, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module ptc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  ptc_pkg::quot_req_t   in,
	output logic                 out_vld,
	output ptc_pkg::div_stage_t  out
);

	logic                vld_s [0:ptc_pkg::DIV_STEPS];
	ptc_pkg::div_stage_t div_s [0:ptc_pkg::DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	// the most negative dividend keeps its pattern as magnitude 2^63
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].rem  <= '0;
			div_s[0].quo  <= in.num[63] ? (~in.num + 64'd1) : in.num;
			div_s[0].den  <= in.den[63] ? (~in.den + 64'd1) : in.den;
			div_s[0].qneg <= in.num[63] ^ in.den[63];
			div_s[0].zero <= (in.den == '0);
			div_s[0].temp <= in.temp;
		end
	end

	for (genvar k = 1; k <= ptc_pkg::DIV_STEPS; k++) begin : g_step
		logic [64:0] trial;
		logic [63:0] shifted;

		always_comb begin
			shifted = {div_s[k-1].rem[62:0], div_s[k-1].quo[63]};
			trial   = {div_s[k-1].rem, div_s[k-1].quo[63]} - {1'b0, div_s[k-1].den};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k].rem  <= trial[64] ? shifted : trial[63:0];
				div_s[k].quo  <= {div_s[k-1].quo[62:0], ~trial[64]};
				div_s[k].den  <= div_s[k-1].den;
				div_s[k].qneg <= div_s[k-1].qneg;
				div_s[k].zero <= div_s[k-1].zero;
				div_s[k].temp <= div_s[k-1].temp;
			end
		end
	end

	assign out_vld = vld_s[ptc_pkg::DIV_STEPS];
	assign out     = div_s[ptc_pkg::DIV_STEPS];

endmodule

// ===== hw/rtl/ptc_post.sv =====
// ----------------------------------------------------------------------------
// ptc_post: pressure correction and output register
// Quadratic correction of the quotient, final shift, saturation and error.
// ----------------------------------------------------------------------------
module ptc_post (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  ptc_pkg::div_stage_t  in,
	input  ptc_pkg::coeff_t      coef,
	output logic                 out_vld,
	output ptc_pkg::result_t     out
);

	logic [7:0] vld_s;

	logic [63:0] q_s1, q_s2, q_s3, q_s4;
	logic        z_s1, z_s2, z_s3, z_s4, z_s5, z_s6, z_s7;
	logic [31:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [63:0] m0_s2;
	logic [31:0] m1_s2, ehi_s2;
	logic signed [48:0] elo_s2;
	logic [63:0] qq_s3, e_s3;
	logic signed [48:0] clo_s4;
	logic [31:0] chi_s4;
	logic [63:0] esh_s4;
	logic [63:0] c_s5, s1_s5, s_s6, r_s7;
	ptc_pkg::result_t res_s8;

	logic [63:0] q13;

	always_comb begin
		q13 = 64'($signed(q_s1) >>> 13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1   <= in.qneg ? (~in.quo + 64'd1) : in.quo;
			z_s1   <= in.zero;
			t_s1   <= in.temp;

			m0_s2  <= q13[31:0] * q13[31:0];
			m1_s2  <= q13[31:0] * q13[63:32];
			elo_s2 <= $signed({1'b0, q_s1[31:0]}) * $signed(coef.p8);
			ehi_s2 <= q_s1[63:32] * {{16{coef.p8[15]}}, coef.p8};
			q_s2   <= q_s1;
			z_s2   <= z_s1;
			t_s2   <= t_s1;

			qq_s3  <= m0_s2 + {m1_s2[30:0], 33'b0};
			e_s3   <= {{15{elo_s2[48]}}, elo_s2} + {ehi_s2, 32'b0};
			q_s3   <= q_s2;
			z_s3   <= z_s2;
			t_s3   <= t_s2;

			clo_s4 <= $signed({1'b0, qq_s3[31:0]}) * $signed(coef.p9);
			chi_s4 <= qq_s3[63:32] * {{16{coef.p9[15]}}, coef.p9};
			esh_s4 <= 64'($signed(e_s3) >>> 19);
			q_s4   <= q_s3;
			z_s4   <= z_s3;
			t_s4   <= t_s3;

			c_s5   <= 64'($signed({{15{clo_s4[48]}}, clo_s4} + {chi_s4, 32'b0}) >>> 25);
			s1_s5  <= q_s4 + esh_s4;
			z_s5   <= z_s4;
			t_s5   <= t_s4;

			s_s6   <= s1_s5 + c_s5;
			z_s6   <= z_s5;
			t_s6   <= t_s5;

			r_s7   <= 64'($signed(s_s6) >>> 8) + {{44{coef.p7[15]}}, coef.p7, 4'b0};
			z_s7   <= z_s6;
			t_s7   <= t_s6;

			// zero divisor drops both values; otherwise clamp to 32 bits
			if (z_s7) begin
				res_s8.temperature_centi <= '0;
				res_s8.pressure_q24_8    <= '0;
				res_s8.status            <= 1'b1;
			end else begin
				res_s8.temperature_centi <= $signed(t_s7);
				if (r_s7[63:31] == '0 || r_s7[63:31] == '1) begin
					res_s8.pressure_q24_8 <= $signed(r_s7[31:0]);
				end else if (r_s7[63]) begin
					res_s8.pressure_q24_8 <= $signed(32'h8000_0000);
				end else begin
					res_s8.pressure_q24_8 <= $signed(32'h7FFF_FFFF);
				end
				res_s8.status <= 1'b0;
			end
		end
	end

	assign out_vld = vld_s[7];
	assign out     = res_s8;

endmodule
